// ===== sv/vector_piecewise_linear_interp_top_assert.svh =====
// Assertion macros shared by the interpolator modules.
// Each expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef VECTOR_PIECEWISE_LINEAR_INTERP_TOP_ASSERT_SVH
`define VECTOR_PIECEWISE_LINEAR_INTERP_TOP_ASSERT_SVH

// Same-cycle implication.
`define VPLI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VPLI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/vpli_pkg.sv =====
package vpli_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_POINTS = 64;
	localparam int DEF_MAX_INNER  = 8;
	localparam int DEF_DATA_WIDTH = 32;

	// Fixed field widths
	localparam int VAL_W  = 32;
	localparam int CMP_W  = 34;
	localparam int QUOT_W = 31;

	// Command codes
	localparam logic [1:0] FUNC_WR_KNOT = 2'd0;
	localparam logic [1:0] FUNC_WR_CTRL = 2'd1;
	localparam logic [1:0] FUNC_QUERY   = 2'd2;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_POINT_COUNT = 2'd0;
	localparam logic [1:0] REG_INNER_COUNT = 2'd1;
	localparam logic [1:0] REG_TOLERANCE   = 2'd2;

	typedef logic [3:0] step_t;

	localparam step_t STEP_IDLE     = 4'd0;
	localparam step_t STEP_LAST     = 4'd1;
	localparam step_t STEP_CLASSIFY = 4'd2;
	localparam step_t STEP_SMID     = 4'd3;
	localparam step_t STEP_SCMP     = 4'd4;
	localparam step_t STEP_BRK      = 4'd5;
	localparam step_t STEP_TP       = 4'd6;
	localparam step_t STEP_TN       = 4'd7;
	localparam step_t STEP_WGT      = 4'd8;
	localparam step_t STEP_DIV      = 4'd9;
	localparam step_t STEP_RDA      = 4'd10;
	localparam step_t STEP_RDB      = 4'd11;
	localparam step_t STEP_MUL      = 4'd12;
	localparam step_t STEP_EMIT     = 4'd13;
	localparam step_t STEP_RET      = 4'd14;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_IDLE,
		OP_LATCH_LAST,
		OP_CLASSIFY,
		OP_SMID,
		OP_SCMP,
		OP_LATCH_TP,
		OP_LATCH_TN,
		OP_WEIGHT,
		OP_DIV,
		OP_LATCH_A,
		OP_MULT,
		OP_EMIT
	} dp_op_t;

	typedef enum logic [2:0] {
		KA_LAST,
		KA_FIRST,
		KA_MID,
		KA_PREV,
		KA_NEXT
	} kaddr_sel_t;

	typedef enum logic {
		CA_PREV,
		CA_NEXT
	} caddr_sel_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOGO,
		C_ENDS,
		C_SDONE,
		C_DIV_SKIP,
		C_DIV_BUSY,
		C_MORE
	} cond_t;

	typedef struct packed {
		dp_op_t     op;
		kaddr_sel_t kaddr;
		caddr_sel_t caddr;
		cond_t      cond;
		step_t      target;
	} ctrl_word_t;

	typedef struct packed {
		logic go;
		logic ends;
		logic sdone;
		logic div_skip;
		logic div_busy;
		logic more;
	} dp_status_t;

	function automatic ctrl_word_t cw_make(input dp_op_t op, input kaddr_sel_t ka,
		input caddr_sel_t ca, input cond_t cond, input step_t target);
		ctrl_word_t w;
		w.op     = op;
		w.kaddr  = ka;
		w.caddr  = ca;
		w.cond   = cond;
		w.target = target;
		return w;
	endfunction

	// Microprogram: a taken condition jumps to target, otherwise fall through.
	function automatic ctrl_word_t ucode(input step_t step);
		ctrl_word_t w;
		unique case (step)
			STEP_IDLE:     w = cw_make(OP_IDLE, KA_LAST, CA_PREV, C_NOGO, STEP_IDLE);
			STEP_LAST:     w = cw_make(OP_LATCH_LAST, KA_FIRST, CA_PREV, C_NEVER, STEP_IDLE);
			STEP_CLASSIFY: w = cw_make(OP_CLASSIFY, KA_MID, CA_PREV, C_ENDS, STEP_RDA);
			STEP_SMID:     w = cw_make(OP_SMID, KA_MID, CA_PREV, C_SDONE, STEP_BRK);
			STEP_SCMP:     w = cw_make(OP_SCMP, KA_MID, CA_PREV, C_ALWAYS, STEP_SMID);
			STEP_BRK:      w = cw_make(OP_NOP, KA_PREV, CA_PREV, C_NEVER, STEP_IDLE);
			STEP_TP:       w = cw_make(OP_LATCH_TP, KA_NEXT, CA_PREV, C_NEVER, STEP_IDLE);
			STEP_TN:       w = cw_make(OP_LATCH_TN, KA_NEXT, CA_PREV, C_NEVER, STEP_IDLE);
			STEP_WGT:      w = cw_make(OP_WEIGHT, KA_NEXT, CA_PREV, C_DIV_SKIP, STEP_RDA);
			STEP_DIV:      w = cw_make(OP_DIV, KA_NEXT, CA_PREV, C_DIV_BUSY, STEP_DIV);
			STEP_RDA:      w = cw_make(OP_NOP, KA_NEXT, CA_PREV, C_NEVER, STEP_IDLE);
			STEP_RDB:      w = cw_make(OP_LATCH_A, KA_NEXT, CA_NEXT, C_NEVER, STEP_IDLE);
			STEP_MUL:      w = cw_make(OP_MULT, KA_NEXT, CA_NEXT, C_NEVER, STEP_IDLE);
			STEP_EMIT:     w = cw_make(OP_EMIT, KA_NEXT, CA_PREV, C_MORE, STEP_RDA);
			STEP_RET:      w = cw_make(OP_NOP, KA_LAST, CA_PREV, C_ALWAYS, STEP_IDLE);
			default:       w = cw_make(OP_NOP, KA_LAST, CA_PREV, C_ALWAYS, STEP_IDLE);
		endcase
		return w;
	endfunction

endpackage

// ===== sv/vpli_ram.sv =====
module vpli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/vpli_div.sv =====
// Restoring divider: quot = (num << 31) / den for 0 < num < den, one bit a cycle.
module vpli_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [vpli_pkg::VAL_W-1:0]    num,
	input  logic [vpli_pkg::VAL_W-1:0]    den,
	output logic                          busy,
	output logic [vpli_pkg::QUOT_W-1:0]   quot
);

	localparam int CNT_W = $clog2(vpli_pkg::QUOT_W + 1);

	logic [CNT_W-1:0]              cnt_q;
	logic [vpli_pkg::VAL_W-1:0]    rem_q;
	logic [vpli_pkg::VAL_W-1:0]    den_q;
	logic [vpli_pkg::QUOT_W-1:0]   quot_q;
	logic [vpli_pkg::VAL_W:0]      rem2;
	logic                          fits;

	assign rem2 = {rem_q, 1'b0};
	assign fits = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(vpli_pkg::QUOT_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= fits ? vpli_pkg::VAL_W'(rem2 - {1'b0, den_q}) : rem2[vpli_pkg::VAL_W-1:0];
			quot_q <= {quot_q[vpli_pkg::QUOT_W-2:0], fits};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quot_q;

endmodule

// ===== sv/vpli_useq.sv =====
// Step counter and microcode table.
module vpli_useq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  vpli_pkg::dp_status_t    st,
	output vpli_pkg::ctrl_word_t    cw,
	output logic                    busy
);

	`include "vector_piecewise_linear_interp_top_assert.svh"

	vpli_pkg::step_t pc_q;
	logic            taken;

	assign cw   = vpli_pkg::ucode(pc_q);
	assign busy = pc_q != vpli_pkg::STEP_IDLE;

	always_comb begin
		unique case (cw.cond)
			vpli_pkg::C_NEVER:    taken = 1'b0;
			vpli_pkg::C_ALWAYS:   taken = 1'b1;
			vpli_pkg::C_NOGO:     taken = !st.go;
			vpli_pkg::C_ENDS:     taken = st.ends;
			vpli_pkg::C_SDONE:    taken = st.sdone;
			vpli_pkg::C_DIV_SKIP: taken = st.div_skip;
			vpli_pkg::C_DIV_BUSY: taken = st.div_busy;
			vpli_pkg::C_MORE:     taken = st.more;
			default:              taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= vpli_pkg::STEP_IDLE;
		end else begin
			pc_q <= taken ? cw.target : pc_q + vpli_pkg::step_t'(1);
		end
	end

	`VPLI_ASSERT_NXT(a_go_busy, st.go, busy, "accepted query did not start the program")
	`VPLI_ASSERT_IMP(a_div_step, st.div_busy, pc_q == vpli_pkg::STEP_DIV,
		"divider running outside the divide step")

endmodule

// ===== sv/vpli_dpath.sv =====
// Datapath: knot and control tables, search registers, weight, blend and result word.
module vpli_dpath #(
	parameter int MAX_POINTS = vpli_pkg::DEF_MAX_POINTS,
	parameter int MAX_INNER  = vpli_pkg::DEF_MAX_INNER,
	parameter int DATA_WIDTH = vpli_pkg::DEF_DATA_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [1:0]                  func,
	input  logic [5:0]                  point_index,
	input  logic [2:0]                  element_index,
	input  logic signed [31:0]          write_value,
	input  logic signed [31:0]          query_time,
	input  logic [6:0]                  point_count,
	input  logic [3:0]                  inner_count,
	input  logic [15:0]                 tolerance,
	input  vpli_pkg::ctrl_word_t        cw,
	output vpli_pkg::dp_status_t        st,
	output logic                        strobe,
	output logic signed [31:0]          element_value,
	output logic [2:0]                  out_element,
	output logic                        out_of_range,
	output logic                        last
);

	localparam int VW     = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam int PW     = $clog2(MAX_POINTS);
	localparam int NW     = PW + 1;
	localparam int IW     = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
	localparam int MW     = IW + 1;
	localparam int CDEPTH = MAX_POINTS * (1 << IW);
	localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
	localparam logic signed [34:0] SAT_LO = -35'sd2147483648;
	localparam logic signed [65:0] RND    = 66'sh0_4000_0000;

	logic              accept;
	logic [NW-1:0]     n_c;
	logic [MW-1:0]     m_c;
	logic [PW-1:0]     last_idx;
	logic [IW-1:0]     m_last;

	logic [VW-1:0]     kn_rdata;
	logic [VW-1:0]     cv_rdata;
	logic [PW-1:0]     kn_raddr;
	logic [PW+IW-1:0]  cv_raddr;
	logic              kn_we;
	logic              cv_we;

	logic signed [31:0] t_q;
	logic signed [31:0] lastk_q;
	logic signed [31:0] tp_q;
	logic signed [31:0] tn_q;
	logic signed [31:0] a_q;
	logic signed [31:0] kn_v;
	logic signed [31:0] cv_v;
	logic [PW-1:0]      lo_q;
	logic [PW-1:0]      hi_q;
	logic [PW-1:0]      mid_q;
	logic [PW-1:0]      mid_c;
	logic [PW-1:0]      prev_q;
	logic [PW-1:0]      next_q;
	logic [IW-1:0]      k_q;
	logic [31:0]        w_q;
	logic               oor_q;

	logic               ends_hi;
	logic               ends_lo;
	logic               oor_hi;
	logic               oor_lo;
	logic signed [32:0] num;
	logic signed [32:0] den;
	logic               w_zero;
	logic               w_one;
	logic               div_start;
	logic               div_busy;
	logic [vpli_pkg::QUOT_W-1:0] div_quot;

	logic signed [32:0] diff;
	logic signed [32:0] wsg;
	logic signed [65:0] prod_d;
	logic signed [65:0] prod_q;
	logic signed [65:0] shifted;
	logic signed [34:0] blend;
	logic signed [31:0] blend_sat;

	logic               strobe_q;
	logic signed [31:0] element_value_q;
	logic [2:0]         out_element_q;
	logic               out_of_range_q;
	logic               last_q;

	function automatic logic signed [vpli_pkg::CMP_W-1:0] CMP_EXT(input logic signed [31:0] v);
		return vpli_pkg::CMP_W'(v);
	endfunction

	assign accept = start && !busy;

	// Clamp the count registers into their usable ranges
	always_comb begin
		if (point_count == '0) begin
			n_c = NW'(1);
		end else if (32'(point_count) > 32'(MAX_POINTS)) begin
			n_c = NW'(MAX_POINTS);
		end else begin
			n_c = NW'(point_count);
		end
		if (inner_count == '0) begin
			m_c = MW'(1);
		end else if (32'(inner_count) > 32'(MAX_INNER)) begin
			m_c = MW'(MAX_INNER);
		end else begin
			m_c = MW'(inner_count);
		end
	end

	assign last_idx = PW'(n_c - NW'(1));
	assign m_last   = IW'(m_c - MW'(1));

	assign kn_we = accept && (func == vpli_pkg::FUNC_WR_KNOT)
		&& (32'(point_index) < 32'(MAX_POINTS));
	assign cv_we = accept && (func == vpli_pkg::FUNC_WR_CTRL)
		&& (32'(point_index) < 32'(MAX_POINTS)) && (32'(element_index) < 32'(MAX_INNER));

	assign mid_c = PW'((NW'(lo_q) + NW'(hi_q)) >> 1);

	always_comb begin
		unique case (cw.kaddr)
			vpli_pkg::KA_LAST:  kn_raddr = last_idx;
			vpli_pkg::KA_FIRST: kn_raddr = '0;
			vpli_pkg::KA_MID:   kn_raddr = mid_c;
			vpli_pkg::KA_PREV:  kn_raddr = lo_q - PW'(1);
			vpli_pkg::KA_NEXT:  kn_raddr = lo_q;
			default:            kn_raddr = '0;
		endcase
	end

	assign cv_raddr = (cw.caddr == vpli_pkg::CA_NEXT) ? {next_q, k_q} : {prev_q, k_q};

	vpli_ram #(
		.WIDTH(VW),
		.DEPTH(MAX_POINTS)
	) u_knot_ram (
		.clk  (clk),
		.we   (kn_we),
		.waddr(PW'(point_index)),
		.wdata(write_value[VW-1:0]),
		.raddr(kn_raddr),
		.rdata(kn_rdata)
	);

	vpli_ram #(
		.WIDTH(VW),
		.DEPTH(CDEPTH)
	) u_ctrl_ram (
		.clk  (clk),
		.we   (cv_we),
		.waddr({PW'(point_index), IW'(element_index)}),
		.wdata(write_value[VW-1:0]),
		.raddr(cv_raddr),
		.rdata(cv_rdata)
	);

	assign kn_v = 32'($signed(kn_rdata));
	assign cv_v = 32'($signed(cv_rdata));

	// Table ends: kn_v holds the first knot during the classify step
	assign ends_hi = t_q >= lastk_q;
	assign ends_lo = t_q <= kn_v;
	assign oor_hi  = CMP_EXT(t_q) > CMP_EXT(lastk_q) + $signed({18'b0, tolerance});
	assign oor_lo  = CMP_EXT(t_q) < CMP_EXT(kn_v) - $signed({18'b0, tolerance});

	assign num       = 33'(t_q) - 33'(tp_q);
	assign den       = 33'(tn_q) - 33'(tp_q);
	assign w_zero    = (den <= 33'sd0) || (num <= 33'sd0);
	assign w_one     = !w_zero && (num >= den);
	assign div_start = (cw.op == vpli_pkg::OP_WEIGHT) && !w_zero && !w_one;

	vpli_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num[31:0]),
		.den   (den[31:0]),
		.busy  (div_busy),
		.quot  (div_quot)
	);

	assign diff   = 33'(cv_v) - 33'(a_q);
	assign wsg    = $signed({1'b0, w_q});
	assign prod_d = diff * wsg;

	assign shifted = (prod_q + RND) >>> 31;
	assign blend   = 35'(a_q) + 35'(shifted);

	always_comb begin
		if (blend > SAT_HI) begin
			blend_sat = 32'sh7FFF_FFFF;
		end else if (blend < SAT_LO) begin
			blend_sat = 32'sh8000_0000;
		end else begin
			blend_sat = blend[31:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cw.op)
			vpli_pkg::OP_IDLE: begin
				if (st.go) begin
					t_q <= 32'($signed(query_time[VW-1:0]));
				end
			end
			vpli_pkg::OP_LATCH_LAST: begin
				lastk_q <= kn_v;
			end
			vpli_pkg::OP_CLASSIFY: begin
				k_q  <= '0;
				lo_q <= PW'(1);
				hi_q <= last_idx;
				w_q  <= '0;
				if (ends_hi) begin
					prev_q <= last_idx;
					next_q <= last_idx;
					oor_q  <= oor_hi;
				end else if (ends_lo) begin
					prev_q <= '0;
					next_q <= '0;
					oor_q  <= oor_lo;
				end else begin
					oor_q <= 1'b0;
				end
			end
			vpli_pkg::OP_SMID: begin
				mid_q <= mid_c;
			end
			vpli_pkg::OP_SCMP: begin
				if (kn_v >= t_q) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q + PW'(1);
				end
			end
			vpli_pkg::OP_LATCH_TP: begin
				tp_q <= kn_v;
			end
			vpli_pkg::OP_LATCH_TN: begin
				tn_q <= kn_v;
			end
			vpli_pkg::OP_WEIGHT: begin
				prev_q <= lo_q - PW'(1);
				next_q <= lo_q;
				w_q    <= w_one ? 32'h8000_0000 : '0;
			end
			vpli_pkg::OP_DIV: begin
				w_q <= {1'b0, div_quot};
			end
			vpli_pkg::OP_LATCH_A: begin
				a_q <= cv_v;
			end
			vpli_pkg::OP_MULT: begin
				prod_q <= prod_d;
			end
			vpli_pkg::OP_EMIT: begin
				k_q             <= k_q + IW'(1);
				element_value_q <= blend_sat;
				out_element_q   <= 3'(k_q);
				out_of_range_q  <= oor_q;
				last_q          <= k_q == m_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cw.op == vpli_pkg::OP_EMIT;
		end
	end

	assign st.go       = accept && (func == vpli_pkg::FUNC_QUERY);
	assign st.ends     = ends_hi || ends_lo;
	assign st.sdone    = lo_q >= hi_q;
	assign st.div_skip = !div_start;
	assign st.div_busy = div_busy;
	assign st.more     = k_q != m_last;

	assign strobe        = strobe_q;
	assign element_value = element_value_q;
	assign out_element   = out_element_q;
	assign out_of_range  = out_of_range_q;
	assign last          = last_q;

endmodule

// ===== sv/vector_piecewise_linear_interp_top.sv =====
// Channel   Handshake                          Payload
// config    psel/penable/pwrite, pready = 1    paddr, pwdata, prdata
// command   start taken when busy is low       func, point_index, element_index,
//                                              write_value, query_time
// result    strobe, one cycle per word         element_value, out_element,
//                                              out_of_range, last
//
// Knot and control writes never raise busy.
// A query raises busy the cycle after it is taken. At or past a table end it skips
// the search and the weight; inside the table it runs a binary search (at most 6
// probes for 64 knots) and a serial divider for the weight, skipped when the weight
// is exactly 0 or 1. The control table has a single read port, read twice per
// element, once for each of the two knots around the query.
// arst_n resets config, step counter, divider and strobe; the tables are not cleared.
// The result receiver cannot stall: each word is strobed for one cycle only.
module vector_piecewise_linear_interp_top #(
	parameter int MAX_POINTS = vpli_pkg::DEF_MAX_POINTS,
	parameter int MAX_INNER  = vpli_pkg::DEF_MAX_INNER,
	parameter int DATA_WIDTH = vpli_pkg::DEF_DATA_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,

	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic [5:0]         point_index,
	input  logic [2:0]         element_index,
	input  logic signed [31:0] write_value,
	input  logic signed [31:0] query_time,

	output logic               strobe,
	output logic signed [31:0] element_value,
	output logic [2:0]         out_element,
	output logic               out_of_range,
	output logic               last
);

	`include "vector_piecewise_linear_interp_top_assert.svh"

	logic [6:0]  point_count_q;
	logic [3:0]  inner_count_q;
	logic [15:0] tolerance_q;
	logic        cfg_wr;

	vpli_pkg::ctrl_word_t cw;
	vpli_pkg::dp_status_t st;

	// Config registers: write on the access phase, decode on the word index
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= 7'd1;
			inner_count_q <= 4'd1;
			tolerance_q   <= 16'd1;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				vpli_pkg::REG_POINT_COUNT: point_count_q <= pwdata[6:0];
				vpli_pkg::REG_INNER_COUNT: inner_count_q <= pwdata[3:0];
				vpli_pkg::REG_TOLERANCE:   tolerance_q   <= pwdata[15:0];
				default: begin
					// unmapped word: drop
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			vpli_pkg::REG_POINT_COUNT: prdata = 32'(point_count_q);
			vpli_pkg::REG_INNER_COUNT: prdata = 32'(inner_count_q);
			vpli_pkg::REG_TOLERANCE:   prdata = 32'(tolerance_q);
			default:                   prdata = '0;
		endcase
	end

	// Step counter and microcode; it advances on the datapath's status flags
	vpli_useq u_useq (
		.clk   (clk),
		.arst_n(arst_n),
		.st    (st),
		.cw    (cw),
		.busy  (busy)
	);

	// Tables, search, weight divider, blend multiplier and the result word
	vpli_dpath #(
		.MAX_POINTS(MAX_POINTS),
		.MAX_INNER (MAX_INNER),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.point_index  (point_index),
		.element_index(element_index),
		.write_value  (write_value),
		.query_time   (query_time),
		.point_count  (point_count_q),
		.inner_count  (inner_count_q),
		.tolerance    (tolerance_q),
		.cw           (cw),
		.st           (st),
		.strobe       (strobe),
		.element_value(element_value),
		.out_element  (out_element),
		.out_of_range (out_of_range),
		.last         (last)
	);

	`VPLI_ASSERT_IMP(a_strobe_busy, strobe, busy, "result word outside a query")
	`VPLI_ASSERT_NXT(a_last_idle, strobe && last, !busy && !strobe,
		"query did not end after its final word")

endmodule
